>>> rtl/ipid_pkg.sv
// Package with the types, codes and sizes shared by the incremental PID controller.
`default_nettype none

package ipid_pkg;

    // Data path sizes.
    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_WIDTH     = 16;
    localparam int ERR_WIDTH      = DATA_WIDTH + 1;
    localparam int TICK_WIDTH     = 16;
    localparam int MODE_WIDTH     = 2;
    localparam int OP_WIDTH       = 2;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 16;

    // Operation codes carried with each input item.
    localparam logic [OP_WIDTH-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_RESTART = 2'd2;

    // Run modes.
    localparam logic [MODE_WIDTH-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_AUTO   = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_DEMAND = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_GAIN_ERROR     = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_GAIN_CHANGE    = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_OUT_MIN        = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_OUT_MAX        = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_RUN_MODE       = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PERIOD_TICKS   = 3'd5;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_REVERSE_ACTING = 3'd6;

    // Configuration reset values.
    localparam logic [DATA_WIDTH-1:0] OUT_MAX_RESET      = 16'd255;
    localparam logic [TICK_WIDTH-1:0] PERIOD_TICKS_RESET = 16'd100;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [GAIN_WIDTH-1:0] gain_error;
        logic [GAIN_WIDTH-1:0] gain_change;
        logic [DATA_WIDTH-1:0] out_min;
        logic [DATA_WIDTH-1:0] out_max;
        logic [MODE_WIDTH-1:0] run_mode;
        logic [TICK_WIDTH-1:0] period_ticks;
        logic                  reverse_acting;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [OP_WIDTH-1:0]   operation;
        logic [DATA_WIDTH-1:0] measured_value;
        logic [DATA_WIDTH-1:0] setpoint;
        logic [DATA_WIDTH-1:0] held_output;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] drive_value;
        logic                  updated;
        logic [ERR_WIDTH-1:0]  error_value;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/ipid_cfg.sv
// Configuration register bank of the incremental PID controller.
`default_nettype none

module ipid_cfg
    import ipid_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the addressed register; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_GAIN_ERROR:     cfg_next.gain_error     = cfg_wdata[GAIN_WIDTH-1:0];
                REG_GAIN_CHANGE:    cfg_next.gain_change    = cfg_wdata[GAIN_WIDTH-1:0];
                REG_OUT_MIN:        cfg_next.out_min        = cfg_wdata[DATA_WIDTH-1:0];
                REG_OUT_MAX:        cfg_next.out_max        = cfg_wdata[DATA_WIDTH-1:0];
                REG_RUN_MODE:       cfg_next.run_mode       = cfg_wdata[MODE_WIDTH-1:0];
                REG_PERIOD_TICKS:   cfg_next.period_ticks   = cfg_wdata[TICK_WIDTH-1:0];
                REG_REVERSE_ACTING: cfg_next.reverse_acting = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_error     <= '0;
            cfg_reg.gain_change    <= '0;
            cfg_reg.out_min        <= '0;
            cfg_reg.out_max        <= OUT_MAX_RESET;
            cfg_reg.run_mode       <= MODE_OFF;
            cfg_reg.period_ticks   <= PERIOD_TICKS_RESET;
            cfg_reg.reverse_acting <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/ipid_core.sv
// Controller state and the combinational compute, restart and tick datapath.
`default_nettype none

module ipid_core
    import ipid_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    result
);

    localparam int GS_WIDTH   = GAIN_WIDTH + 1;
    localparam int PROD_WIDTH = GS_WIDTH + ERR_WIDTH;
    localparam int TERM_WIDTH = PROD_WIDTH - GAIN_FRAC_BITS;
    localparam int SUM_WIDTH  = TERM_WIDTH + 2;

    logic [DATA_WIDTH-1:0] acc_reg,      acc_next;
    logic [DATA_WIDTH-1:0] prev_reg,     prev_next;
    logic [TICK_WIDTH-1:0] elapsed_reg,  elapsed_next;
    logic [DATA_WIDTH-1:0] hold_reg,     hold_next;
    logic [ERR_WIDTH-1:0]  last_err_reg, last_err_next;

    logic                         go;
    logic signed [ERR_WIDTH-1:0]  err;
    logic signed [ERR_WIDTH-1:0]  chg;
    logic signed [GS_WIDTH-1:0]   ge_s;
    logic signed [GS_WIDTH-1:0]   gc_s;
    logic signed [PROD_WIDTH-1:0] prod_e;
    logic signed [PROD_WIDTH-1:0] prod_c;
    logic signed [SUM_WIDTH-1:0]  sum;
    logic [DATA_WIDTH-1:0]        acc_sat;
    logic [DATA_WIDTH-1:0]        drive_new;
    logic [DATA_WIDTH-1:0]        held_clamped;

    // Clamp to the output limits: the upper limit is tested first.
    function automatic logic [DATA_WIDTH-1:0] clamp_out(
        input logic [DATA_WIDTH-1:0] v,
        input logic [DATA_WIDTH-1:0] lo,
        input logic [DATA_WIDTH-1:0] hi
    );
        logic [DATA_WIDTH-1:0] r;
        if ($signed(v) > $signed(hi)) begin
            r = hi;
        end else if ($signed(v) < $signed(lo)) begin
            r = lo;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Compute is allowed on demand, or in auto once the period has elapsed.
    always_comb begin
        case (cfg.run_mode)
            MODE_DEMAND: go = 1'b1;
            MODE_AUTO:   go = (elapsed_reg >= cfg.period_ticks);
            default:     go = 1'b0;
        endcase
    end

    // Error and measurement change, both one bit wider than the data.
    assign err = $signed({item.setpoint[DATA_WIDTH-1], item.setpoint})
               - $signed({item.measured_value[DATA_WIDTH-1], item.measured_value});
    assign chg = $signed({item.measured_value[DATA_WIDTH-1], item.measured_value})
               - $signed({prev_reg[DATA_WIDTH-1], prev_reg});

    // Gains become signed and are negated for reverse acting control.
    assign ge_s = cfg.reverse_acting ? -$signed({1'b0, cfg.gain_error})
                                     :  $signed({1'b0, cfg.gain_error});
    assign gc_s = cfg.reverse_acting ? -$signed({1'b0, cfg.gain_change})
                                     :  $signed({1'b0, cfg.gain_change});

    // Two parallel multiplies; dropping the fraction bits floors each product.
    assign prod_e = ge_s * err;
    assign prod_c = gc_s * chg;

    always_comb begin
        sum = $signed({{2{acc_reg[DATA_WIDTH-1]}},
                       {(TERM_WIDTH-DATA_WIDTH){acc_reg[DATA_WIDTH-1]}}, acc_reg})
            + $signed({{2{prod_e[PROD_WIDTH-1]}}, prod_e[PROD_WIDTH-1:GAIN_FRAC_BITS]})
            - $signed({{2{prod_c[PROD_WIDTH-1]}}, prod_c[PROD_WIDTH-1:GAIN_FRAC_BITS]});
    end

    // Saturate the accumulator to the data width.
    always_comb begin
        if ((&sum[SUM_WIDTH-1:DATA_WIDTH-1]) || !(|sum[SUM_WIDTH-1:DATA_WIDTH-1])) begin
            acc_sat = sum[DATA_WIDTH-1:0];
        end else if (sum[SUM_WIDTH-1]) begin
            acc_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    assign drive_new    = clamp_out(acc_sat, cfg.out_min, cfg.out_max);
    assign held_clamped = clamp_out(item.held_output, cfg.out_min, cfg.out_max);

    // Next state for the item that moves to the result register.
    always_comb begin
        acc_next      = acc_reg;
        prev_next     = prev_reg;
        elapsed_next  = elapsed_reg;
        hold_next     = hold_reg;
        last_err_next = last_err_reg;
        result.updated = 1'b0;
        case (item.operation)
            OP_TICK: begin
                if (!(&elapsed_reg)) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            OP_COMPUTE: begin
                if (go) begin
                    acc_next       = acc_sat;
                    hold_next      = drive_new;
                    prev_next      = item.measured_value;
                    last_err_next  = err;
                    elapsed_next   = '0;
                    result.updated = 1'b1;
                end
            end
            OP_RESTART: begin
                prev_next     = item.measured_value;
                acc_next      = held_clamped;
                elapsed_next  = '0;
                last_err_next = '0;
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
        result.drive_value = hold_next;
        result.error_value = last_err_next;
    end

    // State advances only when an item is taken into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            prev_reg     <= '0;
            elapsed_reg  <= '1;
            hold_reg     <= '0;
            last_err_reg <= '0;
        end else if (fire) begin
            acc_reg      <= acc_next;
            prev_reg     <= prev_next;
            elapsed_reg  <= elapsed_next;
            hold_reg     <= hold_next;
            last_err_reg <= last_err_next;
        end
    end

    // State holds while no item is processed.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(acc_reg) && $stable(elapsed_reg) && $stable(hold_reg))
        else $error("controller state changed without an item");

    // A tick below saturation advances the timer by one.
    a_tick_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation == OP_TICK && !(&elapsed_reg)
        |=> elapsed_reg == $past(elapsed_reg) + 1'b1)
        else $error("tick did not advance the timer");

    // A restart clears the timer and the stored error.
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation == OP_RESTART
        |=> elapsed_reg == '0 && last_err_reg == '0)
        else $error("restart left timer or error set");

    // Only an accepted compute in a running mode reports a new output.
    a_update_source: assert property (@(posedge aclk) disable iff (!aresetn)
        result.updated |-> item.operation == OP_COMPUTE && cfg.run_mode != MODE_OFF)
        else $error("update flagged for an item that cannot compute");

endmodule

`default_nettype wire

>>> rtl/incremental_pid_controller.sv
// Top level of the incremental PID controller: stream ports, input and result registers.
//
//  Channel  Direction  Handshake            Content
//  s_       in         s_tvalid / s_tready  operation in tuser, measurement data in tdata
//  m_       out        m_tvalid / m_tready  updated flag in tuser, drive and error in tdata
//  cfg_     in         cfg_we               register index and write data, no read-back
//
// One item is accepted per cycle while the result stream is not stalled.
// All arithmetic for an item happens between the input register and the result register,
// so the accumulator feeds the next item directly and no item waits on another.
// Synchronous active-low reset clears both valid flags and resets the state and config.
// When m_tready is low the result register holds, then the input register fills and
// s_tready drops; nothing is lost or repeated.
`default_nettype none

module incremental_pid_controller
    import ipid_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Input stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // [15:0] measured_value, [31:16] setpoint, [47:32] held_output
    input  wire logic [47:0]               s_tdata,
    // [1:0] operation
    input  wire logic [OP_WIDTH-1:0]       s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // [15:0] drive_value, [32:16] error_value, [39:33] zero
    output logic [39:0]                    m_tdata,
    // [0] updated
    output logic                           m_tuser,
    // Configuration write port
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_load;
    logic    fire;

    ipid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ipid_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (in_item_reg),
        .result  (core_result)
    );

    // The result register takes a new item when empty or being drained.
    assign out_load = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.operation      <= s_tuser;
            in_item_reg.measured_value <= s_tdata[15:0];
            in_item_reg.setpoint       <= s_tdata[31:16];
            in_item_reg.held_output    <= s_tdata[47:32];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.updated;
    assign m_tdata  = {7'd0, out_res_reg.error_value, out_res_reg.drive_value};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the incremental PID controller with a built-in output predictor.
`timescale 1ns / 1ps

module tb_top;
    import ipid_pkg::*;

    // Codes that the package leaves unnamed but the fields can still carry.
    localparam logic [OP_WIDTH-1:0]   OP_NOP      = 2'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
    localparam int STUCK_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int RANDOM_PHASES = 8;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // [15:0] measured_value, [31:16] setpoint, [47:32] held_output
    logic [47:0]               s_tdata = '0;
    // [1:0] operation
    logic [OP_WIDTH-1:0]       s_tuser = OP_TICK;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // [15:0] drive_value, [32:16] error_value, [39:33] zero
    logic [39:0]               m_tdata;
    // [0] updated
    logic                      m_tuser;
    logic                      cfg_we = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = REG_GAIN_ERROR;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

    // Predictor copy of the configuration.
    logic [GAIN_WIDTH-1:0]        cfg_gain_error = '0;
    logic [GAIN_WIDTH-1:0]        cfg_gain_change = '0;
    logic signed [DATA_WIDTH-1:0] cfg_out_min = '0;
    logic signed [DATA_WIDTH-1:0] cfg_out_max = OUT_MAX_RESET;
    logic [MODE_WIDTH-1:0]        cfg_run_mode = MODE_OFF;
    logic [TICK_WIDTH-1:0]        cfg_period = PERIOD_TICKS_RESET;
    logic                         cfg_reverse = 1'b0;

    // Predictor copy of the controller state.
    logic signed [DATA_WIDTH-1:0] pid_accum = '0;
    logic signed [DATA_WIDTH-1:0] pid_prev_meas = '0;
    logic signed [DATA_WIDTH-1:0] pid_hold = '0;
    logic signed [ERR_WIDTH-1:0]  pid_last_error = '0;
    logic [TICK_WIDTH-1:0]        pid_elapsed = '1;

    result_t predicted_results[$];
    int      mismatch_count = 0;
    int      stuck_cycles = 0;
    bit      reset_done = 1'b0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;
    logic signed [DATA_WIDTH-1:0] target_level = '0;

    incremental_pid_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Clamp to the output limits; the upper limit is tested first.
    function automatic logic signed [DATA_WIDTH-1:0] clamp_drive(longint v);
        if (v > longint'(cfg_out_max)) begin
            return cfg_out_max;
        end
        if (v < longint'(cfg_out_min)) begin
            return cfg_out_min;
        end
        return DATA_WIDTH'(v);
    endfunction

    // Advance the controller state by one item and return the result it gives.
    function automatic result_t next_pid_result(logic [OP_WIDTH-1:0] op,
                                                logic signed [DATA_WIDTH-1:0] meas,
                                                logic signed [DATA_WIDTH-1:0] sp,
                                                logic signed [DATA_WIDTH-1:0] held);
        longint  err;
        longint  chg;
        longint  ge;
        longint  gc;
        longint  sum;
        result_t r;
        r.drive_value = pid_hold;
        r.updated = 1'b0;
        case (op)
            OP_TICK: begin
                if (pid_elapsed != '1) begin
                    pid_elapsed = pid_elapsed + 1'b1;
                end
            end
            OP_COMPUTE: begin
                if (cfg_run_mode == MODE_DEMAND ||
                    (cfg_run_mode == MODE_AUTO && pid_elapsed >= cfg_period)) begin
                    err = longint'(sp) - longint'(meas);
                    chg = longint'(meas) - longint'(pid_prev_meas);
                    ge = longint'(cfg_gain_error);
                    gc = longint'(cfg_gain_change);
                    if (cfg_reverse) begin
                        ge = -ge;
                        gc = -gc;
                    end
                    // Each product is floored on its own before the sum.
                    sum = longint'(pid_accum) + ((ge * err) >>> GAIN_FRAC_BITS)
                          - ((gc * chg) >>> GAIN_FRAC_BITS);
                    if (sum > 32767) begin
                        sum = 32767;
                    end else if (sum < -32768) begin
                        sum = -32768;
                    end
                    pid_accum = DATA_WIDTH'(sum);
                    pid_hold = clamp_drive(sum);
                    pid_prev_meas = meas;
                    pid_last_error = ERR_WIDTH'(err);
                    pid_elapsed = '0;
                    r.drive_value = pid_hold;
                    r.updated = 1'b1;
                end
            end
            OP_RESTART: begin
                pid_prev_meas = meas;
                pid_accum = clamp_drive(longint'(held));
                pid_elapsed = '0;
                pid_last_error = '0;
            end
            default: begin
            end
        endcase
        r.error_value = pid_last_error;
        return r;
    endfunction

    // Send one item after a random gap (none when tx_steady is set) and record its expected result once accepted.
    task automatic send_item(input logic [OP_WIDTH-1:0] op,
                             input logic signed [DATA_WIDTH-1:0] meas,
                             input logic signed [DATA_WIDTH-1:0] sp,
                             input logic signed [DATA_WIDTH-1:0] held);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {held, sp, meas};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted_results.push_back(next_pid_result(op, meas, sp, held));
    endtask

    // Stop sending and wait until every result has come back and the block is quiet.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register and mirror it in the predictor.
    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (addr)
            REG_GAIN_ERROR:     cfg_gain_error = value;
            REG_GAIN_CHANGE:    cfg_gain_change = value;
            REG_OUT_MIN:        cfg_out_min = value;
            REG_OUT_MAX:        cfg_out_max = value;
            REG_RUN_MODE:       cfg_run_mode = value[MODE_WIDTH-1:0];
            REG_PERIOD_TICKS:   cfg_period = value;
            REG_REVERSE_ACTING: cfg_reverse = value[0];
            default: begin
            end
        endcase
    endtask

    task automatic program_regs(input logic [15:0] ge, input logic [15:0] gc,
                                input logic [15:0] lo, input logic [15:0] hi,
                                input logic [MODE_WIDTH-1:0] mode,
                                input logic [15:0] period, input logic rev);
        wait_for_results();
        write_reg(REG_GAIN_ERROR, ge);
        write_reg(REG_GAIN_CHANGE, gc);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        write_reg(REG_RUN_MODE, 16'(mode));
        write_reg(REG_PERIOD_TICKS, period);
        write_reg(REG_REVERSE_ACTING, 16'(rev));
    endtask

    // Reset state: refused computes, saturated timer allows the first auto compute,
    // and the default output limits apply.
    task automatic test_reset_state();
        send_item(OP_COMPUTE, 16'sd10, 16'sd50, 16'sd0);
        send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
        wait_for_results();
        write_reg(REG_RUN_MODE, 16'(MODE_AUTO));
        send_item(OP_COMPUTE, 16'sd20, 16'sd40, 16'sd0);
        send_item(OP_COMPUTE, 16'sd20, 16'sd40, 16'sd0);
        wait_for_results();
        write_reg(REG_RUN_MODE, 16'(MODE_DEMAND));
        send_item(OP_RESTART, 16'sd5, 16'sd0, 16'sd1000);
        send_item(OP_COMPUTE, 16'sd5, 16'sd5, 16'sd0);
    endtask

    // Full-scale errors and changes with the largest gains, both acting directions,
    // and flooring of small negative products.
    task automatic test_extremes();
        program_regs(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, MODE_DEMAND, 16'd1, 1'b0);
        send_item(OP_RESTART, 16'sd0, 16'sd0, 16'sh7FFF);
        send_item(OP_COMPUTE, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_COMPUTE, 16'sh7FFF, 16'sh8000, 16'sh8000);
        program_regs(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, MODE_DEMAND, 16'd1, 1'b1);
        send_item(OP_COMPUTE, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        program_regs(16'd1, 16'd0, 16'h8000, 16'h7FFF, MODE_DEMAND, 16'd1, 1'b0);
        send_item(OP_RESTART, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_COMPUTE, 16'sd1, 16'sd0, 16'sd0);
    endtask

    // Auto mode pacing by ticks, a zero period and the longest period.
    task automatic test_auto_pacing();
        program_regs(16'd256, 16'd128, 16'h8000, 16'h7FFF, MODE_AUTO, 16'd3, 1'b0);
        send_item(OP_RESTART, 16'sd0, 16'sd100, 16'sd0);
        send_item(OP_COMPUTE, 16'sd10, 16'sd100, 16'sd0);
        send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_COMPUTE, 16'sd10, 16'sd100, 16'sd0);
        send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_COMPUTE, 16'sd10, 16'sd100, 16'sd0);
        program_regs(16'd256, 16'd128, 16'h8000, 16'h7FFF, MODE_AUTO, 16'd0, 1'b0);
        send_item(OP_COMPUTE, 16'sd20, 16'sd100, 16'sd0);
        send_item(OP_COMPUTE, 16'sd30, 16'sd100, 16'sd0);
        program_regs(16'd256, 16'd128, 16'h8000, 16'h7FFF, MODE_AUTO, 16'hFFFF, 1'b0);
        send_item(OP_RESTART, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_COMPUTE, 16'sd30, 16'sd100, 16'sd0);
    endtask

    // With out_min above out_max, values above out_max give out_max and others give out_min.
    task automatic test_inverted_limits();
        program_regs(16'd0, 16'd0, 16'd100, 16'hFF9C, MODE_DEMAND, 16'd1, 1'b0);
        send_item(OP_RESTART, 16'sd0, 16'sd0, 16'sd200);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_RESTART, 16'sd0, 16'sd0, -16'sd200);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0, 16'sd0);
    endtask

    // The unused operation code and the unused run mode change nothing.
    task automatic test_unused_codes();
        send_item(OP_NOP, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        program_regs(16'd512, 16'd512, 16'h8000, 16'h7FFF, MODE_UNUSED, 16'd1, 1'b0);
        send_item(OP_COMPUTE, 16'sd7, 16'sd900, 16'sd0);
        send_item(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_COMPUTE, 16'sd7, 16'sd900, 16'sd0);
    endtask

    task automatic random_settings();
        logic [15:0] ge;
        logic [15:0] gc;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] period;
        logic [MODE_WIDTH-1:0] mode;
        int pick;
        // Gains are mostly moderate so the loop does not saturate at once.
        pick = $urandom_range(0, 9);
        ge = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 :
             (pick == 2) ? 16'($urandom) : 16'($urandom_range(0, 2047));
        pick = $urandom_range(0, 9);
        gc = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 :
             (pick == 2) ? 16'($urandom) : 16'($urandom_range(0, 2047));
        // Limits: full range, a random pair in either order, or an ordered random pair.
        pick = $urandom_range(0, 9);
        a = 16'($urandom);
        b = 16'($urandom);
        if (pick < 2) begin
            a = 16'h8000;
            b = 16'h7FFF;
        end else if (pick > 2 && $signed(a) > $signed(b)) begin
            {a, b} = {b, a};
        end
        pick = $urandom_range(0, 19);
        mode = (pick < 9) ? MODE_DEMAND : (pick < 17) ? MODE_AUTO :
               (pick < 19) ? MODE_OFF : MODE_UNUSED;
        pick = $urandom_range(0, 9);
        period = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) :
                 16'($urandom_range(1, 6));
        program_regs(ge, gc, a, b, mode, period, 1'($urandom_range(0, 1)));
    endtask

    // Random phases: mostly ticks and computes near a drifting setpoint, with restarts,
    // full-range noise and occasional drains of the result stream.
    task automatic test_random_traffic();
        int pick;
        int noise;
        logic [OP_WIDTH-1:0] op;
        logic signed [DATA_WIDTH-1:0] meas;
        logic signed [DATA_WIDTH-1:0] sp;
        logic signed [DATA_WIDTH-1:0] held;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_settings();
            send_item(OP_RESTART, target_level, target_level, 16'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 50 == 0) begin
                    tx_steady = ($urandom_range(0, 3) == 0);
                    rx_steady = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 99) == 0) begin
                    wait_for_results();
                end
                pick = $urandom_range(0, 99);
                op = (pick < 55) ? OP_COMPUTE : (pick < 85) ? OP_TICK :
                     (pick < 97) ? OP_RESTART : OP_NOP;
                if ($urandom_range(0, 19) == 0) begin
                    target_level = 16'($urandom);
                end
                noise = int'($urandom_range(0, 255)) - 128;
                sp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : target_level;
                meas = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(int'(sp) + noise);
                held = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                       16'(int'($urandom_range(0, 511)) - 256);
                send_item(op, meas, sp, held);
            end
        end
    endtask

    // Result checker: takes results after random stalls (none when rx_steady is set) and compares them in order.
    initial begin : result_checker
        result_t want;
        int stall;
        wait (reset_done);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (predicted_results.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual drive %0d updated %0b",
                         $time, $signed(m_tdata[15:0]), m_tuser);
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                if (m_tdata[15:0] !== want.drive_value) begin
                    $display("%0t: drive_value mismatch: expected %0d, actual %0d", $time,
                             $signed(want.drive_value), $signed(m_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_tuser !== want.updated) begin
                    $display("%0t: updated mismatch: expected %0b, actual %0b", $time,
                             want.updated, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[32:16] !== want.error_value) begin
                    $display("%0t: error_value mismatch: expected %0d, actual %0d", $time,
                             $signed(want.error_value), $signed(m_tdata[32:16]));
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles with no item moving on either side ends the run.
    always @(posedge aclk) begin
        if (!reset_done || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : test_sequence
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        reset_done = 1'b1;
        test_reset_state();
        test_extremes();
        test_auto_pacing();
        test_inverted_limits();
        test_unused_codes();
        test_random_traffic();
        rx_steady = 1'b1;
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
